// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and silenced while reset is asserted.
`define HTOK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and silenced while reset is asserted.
`define HTOK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/htok_pkg.sv -----
`default_nettype none

package htok_pkg;

	// Sizing of the tokenizer.
	localparam int MAX_BYTES = 4096;
	localparam int MAX_PAIRS = 32;

	// Field widths of the result record.
	localparam int OFF_W     = 12;
	localparam int CNT_OUT_W = 6;

	// Internal widths that follow from the sizing.
	localparam int POS_W = $clog2(MAX_BYTES + 1);
	localparam int CNT_W = $clog2(MAX_PAIRS + 1);

	// Result queue: depth must be a power of two, at least four.
	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Record kinds.
	localparam logic KIND_PAIR   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_CRLF  = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic                 record_kind;
		logic [OFF_W-1:0]     name_start;
		logic [OFF_W-1:0]     name_end;
		logic [OFF_W-1:0]     value_start;
		logic [OFF_W-1:0]     value_end;
		logic [1:0]           parse_status;
		logic [CNT_OUT_W-1:0] pair_count;
		logic                 last_record;
	} rec_t;

	// Records written into the result queue in one cycle.
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

`default_nettype wire

// ----- rtl/htok_core.sv -----
`default_nettype none

module htok_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire htok_pkg::item_t item,
	output htok_pkg::push_t     push,
	output htok_pkg::rec_t      wdata0,
	output htok_pkg::rec_t      wdata1
);
	import htok_pkg::*;

	localparam logic PH_REQLINE = 1'b0;
	localparam logic PH_FIELDS  = 1'b1;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	logic             phase_q, phase_d;
	logic             scr_q, scr_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             name_open_q, name_open_d;
	logic [OFF_W-1:0] name_begin_q, name_begin_d;
	logic [OFF_W-1:0] name_colon_q, name_colon_d;
	logic             value_open_q, value_open_d;
	logic [OFF_W-1:0] value_begin_q, value_begin_d;
	logic             skip_q, skip_d;
	logic [CNT_W-1:0] pairs_q, pairs_d;
	logic [1:0]       err_q, err_d;
	logic             emit_pair;
	logic [1:0]       status;
	rec_t             pair_rec;
	rec_t             stat_rec;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	always_comb begin
		logic [7:0] b;
		logic       eol;
		b = item.byte_value;
		eol = (b == CH_CR) || (b == CH_LF);
		phase_d = phase_q;
		scr_d = scr_q;
		name_open_d = name_open_q;
		name_begin_d = name_begin_q;
		name_colon_d = name_colon_q;
		value_open_d = value_open_q;
		value_begin_d = value_begin_q;
		skip_d = skip_q;
		pairs_d = pairs_q;
		err_d = err_q;
		emit_pair = 1'b0;

		if (err_q == ST_OK) begin
			if (pos_q >= POS_W'(MAX_BYTES)) begin
				err_d = ST_TOO_LONG;
			end else if (phase_q == PH_REQLINE) begin
				if (scr_q && b == CH_LF) begin
					phase_d = PH_FIELDS;
				end
				scr_d = (b == CH_CR);
			end else begin
				if (skip_q && !(b == CH_SPACE && !item.last_byte)) begin
					value_begin_d = OFF_W'(pos_q);
					skip_d = 1'b0;
				end
				if (name_open_q && value_open_q && eol) begin
					if (pairs_q < CNT_W'(MAX_PAIRS)) begin
						pairs_d = pairs_q + 1'b1;
						emit_pair = 1'b1;
						name_open_d = 1'b0;
						value_open_d = 1'b0;
					end else begin
						err_d = ST_TOO_MANY;
					end
				end else if (name_open_q && !value_open_q && !item.last_byte
						&& b == CH_COLON) begin
					name_colon_d = OFF_W'(pos_q);
					value_open_d = 1'b1;
					value_begin_d = OFF_W'(pos_q + 1'b1);
					skip_d = 1'b1;
				end else if (!name_open_q && is_letter(b)) begin
					name_open_d = 1'b1;
					name_begin_d = OFF_W'(pos_q);
				end
			end
		end

		pos_d = (pos_q < POS_W'(MAX_BYTES)) ? pos_q + 1'b1 : pos_q;
	end

	always_comb begin
		if (err_d != ST_OK) begin
			status = err_d;
		end else if (phase_d == PH_REQLINE) begin
			status = ST_NO_CRLF;
		end else begin
			status = ST_OK;
		end

		pair_rec.record_kind  = KIND_PAIR;
		pair_rec.name_start   = name_begin_q;
		pair_rec.name_end     = name_colon_q;
		pair_rec.value_start  = value_begin_d;
		pair_rec.value_end    = OFF_W'(pos_q);
		pair_rec.parse_status = ST_OK;
		pair_rec.pair_count   = CNT_OUT_W'(pairs_d);
		pair_rec.last_record  = 1'b0;

		stat_rec.record_kind  = KIND_STATUS;
		stat_rec.name_start   = '0;
		stat_rec.name_end     = '0;
		stat_rec.value_start  = '0;
		stat_rec.value_end    = '0;
		stat_rec.parse_status = status;
		stat_rec.pair_count   = CNT_OUT_W'(pairs_d);
		stat_rec.last_record  = 1'b1;
	end

	assign push.first  = step && (emit_pair || item.last_byte);
	assign push.second = step && emit_pair && item.last_byte;
	assign wdata0 = emit_pair ? pair_rec : stat_rec;
	assign wdata1 = stat_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_REQLINE;
			scr_q <= 1'b0;
			pos_q <= '0;
			name_open_q <= 1'b0;
			name_begin_q <= '0;
			name_colon_q <= '0;
			value_open_q <= 1'b0;
			value_begin_q <= '0;
			skip_q <= 1'b0;
			pairs_q <= '0;
			err_q <= ST_OK;
		end else if (step) begin
			if (item.last_byte) begin
				// The final byte of a buffer returns the tokenizer to its reset state.
				phase_q <= PH_REQLINE;
				scr_q <= 1'b0;
				pos_q <= '0;
				name_open_q <= 1'b0;
				name_begin_q <= '0;
				name_colon_q <= '0;
				value_open_q <= 1'b0;
				value_begin_q <= '0;
				skip_q <= 1'b0;
				pairs_q <= '0;
				err_q <= ST_OK;
			end else begin
				phase_q <= phase_d;
				scr_q <= scr_d;
				pos_q <= pos_d;
				name_open_q <= name_open_d;
				name_begin_q <= name_begin_d;
				name_colon_q <= name_colon_d;
				value_open_q <= value_open_d;
				value_begin_q <= value_begin_d;
				skip_q <= skip_d;
				pairs_q <= pairs_d;
				err_q <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/htok_fifo.sv -----
`default_nettype none

module htok_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire htok_pkg::push_t push,
	input  wire htok_pkg::rec_t  wdata0,
	input  wire htok_pkg::rec_t  wdata1,
	input  wire logic           rec_ready,
	output logic                rec_valid,
	output htok_pkg::rec_t      rec,
	output logic                room
);
	import htok_pkg::*;

	rec_t              queue_q [QDEPTH];
	logic [QA_W-1:0]   wp_q;
	logic [QA_W-1:0]   rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [1:0]        n_push;
	logic              pop;

	assign n_push = {1'b0, push.first} + {1'b0, push.second};
	assign pop = rec_valid && rec_ready;
	assign rec_valid = (cnt_q != '0);
	assign rec = queue_q[rp_q];
	// Two free places are always kept for the worst case of one byte.
	assign room = (cnt_q <= QCNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.first) begin
			queue_q[wp_q] <= wdata0;
		end
		if (push.second) begin
			queue_q[wp_q + 1'b1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + QA_W'(n_push);
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/http_header_tokenizer.sv -----
// Path: a transferred byte is registered in the input stage, and from there its records are
// written into the result queue, whose head drives rec.
// Throughput: one byte per cycle while the result queue has room; a final byte that also
// closes a header pair yields two records, which leave through the result queue in turn.
// Reset: arst_n clears the input stage, the tokenizer state and the result queue at once.
`default_nettype none

module http_header_tokenizer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire htok_pkg::item_t item,
	output logic                rec_valid,
	input  wire logic           rec_ready,
	output htok_pkg::rec_t      rec
);
	import htok_pkg::*;

	// The input stage holds one byte. It is processed in the cycle in which it sits
	// in this register, provided the result queue has space for the two records that
	// a single byte can produce at most. The tokenizer then updates its state and
	// writes its records into the queue at the same edge.
	logic   valid_s1;
	item_t  item_s1;
	logic   room;
	logic   advance;
	push_t  push;
	rec_t   wdata0;
	rec_t   wdata1;

	assign advance = valid_s1 && room;

	// A new byte is taken whenever the stage is empty or is being emptied this cycle,
	// so a stalled consumer only holds up the input once the queue is nearly full.
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Header tokenizer: request line skip, name and value tracking, pair count and
	// error latching, all updated from the byte in the input stage.
	htok_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.push   (push),
		.wdata0 (wdata0),
		.wdata1 (wdata1)
	);

	// Result queue: it separates the consumer's ready from the input side, and it
	// absorbs the pair record and the status record that a final byte may produce together.
	htok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata0    (wdata0),
		.wdata1    (wdata1),
		.rec_ready (rec_ready),
		.rec_valid (rec_valid),
		.rec       (rec),
		.room      (room)
	);

endmodule

`default_nettype wire

// ----- rtl/htok_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module htok_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           item_valid,
	input wire logic           item_ready,
	input wire htok_pkg::item_t item,
	input wire logic           rec_valid,
	input wire logic           rec_ready,
	input wire htok_pkg::rec_t  rec
);
	import htok_pkg::*;

	`HTOK_ASSERT_NXT(a_rec_hold, rec_valid && !rec_ready, rec_valid && $stable(rec), "record changed while stalled")
	`HTOK_ASSERT_IMP(a_pair_shape, rec_valid && rec.record_kind == KIND_PAIR, !rec.last_record && rec.parse_status == ST_OK && rec.pair_count != '0 && rec.name_start < rec.name_end && rec.name_end < rec.value_start && rec.value_start <= rec.value_end, "malformed pair record")
	`HTOK_ASSERT_IMP(a_status_shape, rec_valid && rec.record_kind == KIND_STATUS, rec.last_record && rec.name_start == '0 && rec.name_end == '0 && rec.value_start == '0 && rec.value_end == '0, "malformed status record")
	`HTOK_ASSERT_NXT(a_item_hold, item_valid && !item_ready, item_valid && $stable(item), "input changed while waiting")

endmodule

bind http_header_tokenizer htok_checker u_htok_checker (.*);

`default_nettype wire
